### sv/tapc_pkg.sv
`timescale 1ns / 1ps
package tapc_pkg;

   localparam int VAL_W   = 23;
   localparam int MS_W    = 16;
   localparam int STEP_W  = VAL_W + MS_W;
   localparam int ARITH_W = STEP_W + 3;
   localparam int PCT_W   = 7;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic [VAL_W-1:0] FULL_SCALE   = VAL_W'(6553600);
   localparam logic [VAL_W-1:0] HALF_PERCENT = VAL_W'(32768);

   localparam logic [VAL_W-1:0] RATE_RESET     = VAL_W'(109);
   localparam logic [VAL_W-1:0] DEADBAND_RESET = VAL_W'(32768);

   typedef enum logic [1:0] {
      REG_RATE_PER_MS     = 2'd0,
      REG_DEADBAND        = 2'd1,
      REG_USE_LEFT_MOTOR  = 2'd2,
      REG_USE_RIGHT_MOTOR = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_SET_TARGET = 2'd1,
      OP_RESTORE    = 2'd2,
      OP_NONE       = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_STOPPED = 2'd0,
      MODE_OPENING = 2'd1,
      MODE_CLOSING = 2'd2
   } mode_type;

   typedef struct packed {
      logic [VAL_W-1:0] rate_per_ms;
      logic [VAL_W-1:0] deadband;
      logic             use_left_motor;
      logic             use_right_motor;
   } cfg_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [STEP_W-1:0] step;
      logic [VAL_W-1:0]  value;
   } stage_type;

endpackage

### sv/timed_actuator_position_controller_top.sv
`timescale 1ns / 1ps
// Path: an accepted request is held in the input register, then in the result
// register; a response stall can hold it in either.
// Throughput: one item per cycle while rsp_stall is low; the state update
// (position, target, mode) is one registered pass, and the tick travel
// product is formed in the input register stage.
// Reset: synchronous; clears position, target and mode, restores register
// defaults, and empties both pipeline registers.
module timed_actuator_position_controller_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_opcode,
   input  logic [tapc_pkg::MS_W-1:0]   req_elapsed_ms,
   input  logic [tapc_pkg::VAL_W-1:0]  req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_motion_state,
   output logic                        rsp_direction_up,
   output logic                        rsp_left_enable,
   output logic                        rsp_right_enable,
   output logic [tapc_pkg::PCT_W-1:0]  rsp_position_percent,
   output logic                        rsp_stopped_now,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [tapc_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [tapc_pkg::DATA_W-1:0] csr_pwdata,
   output logic [tapc_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);
   import tapc_pkg::*;

   cfg_type   cfg;
   stage_type stage;
   logic      stage_valid;
   logic      stage_stall;

   tapc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tapc_ingress u_ingress (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_elapsed_ms (req_elapsed_ms),
      .req_value      (req_value),
      .rate_per_ms    (cfg.rate_per_ms),
      .stage_valid    (stage_valid),
      .stage_stall    (stage_stall),
      .stage          (stage)
   );

   tapc_core u_core (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .stage_valid          (stage_valid),
      .stage_stall          (stage_stall),
      .stage                (stage),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_motion_state     (rsp_motion_state),
      .rsp_direction_up     (rsp_direction_up),
      .rsp_left_enable      (rsp_left_enable),
      .rsp_right_enable     (rsp_right_enable),
      .rsp_position_percent (rsp_position_percent),
      .rsp_stopped_now      (rsp_stopped_now)
   );

endmodule

### sv/tapc_csr.sv
`timescale 1ns / 1ps
module tapc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [tapc_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [tapc_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [tapc_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready,
   output tapc_pkg::cfg_type            cfg
);
   import tapc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_RATE_PER_MS:     cfg_in.rate_per_ms     = csr_pwdata[VAL_W-1:0];
            REG_DEADBAND:        cfg_in.deadband        = csr_pwdata[VAL_W-1:0];
            REG_USE_LEFT_MOTOR:  cfg_in.use_left_motor  = csr_pwdata[0];
            REG_USE_RIGHT_MOTOR: cfg_in.use_right_motor = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_RATE_PER_MS:     csr_prdata = DATA_W'(cfg_ff.rate_per_ms);
         REG_DEADBAND:        csr_prdata = DATA_W'(cfg_ff.deadband);
         REG_USE_LEFT_MOTOR:  csr_prdata = DATA_W'(cfg_ff.use_left_motor);
         REG_USE_RIGHT_MOTOR: csr_prdata = DATA_W'(cfg_ff.use_right_motor);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_per_ms     <= RATE_RESET;
         cfg_ff.deadband        <= DEADBAND_RESET;
         cfg_ff.use_left_motor  <= 1'b1;
         cfg_ff.use_right_motor <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/tapc_ingress.sv
`timescale 1ns / 1ps
module tapc_ingress (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_opcode,
   input  logic [tapc_pkg::MS_W-1:0]   req_elapsed_ms,
   input  logic [tapc_pkg::VAL_W-1:0]  req_value,
   input  logic [tapc_pkg::VAL_W-1:0]  rate_per_ms,
   output logic                        stage_valid,
   input  logic                        stage_stall,
   output tapc_pkg::stage_type         stage
);
   import tapc_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   stage_type stage_ff;
   stage_type stage_in;
   logic      accept;

   assign req_stall = valid_ff && stage_stall;
   assign accept    = req_valid && !req_stall;

   // precompute travel for this tick so the core only adds and compares
   always_comb begin
      stage_in.opcode = opcode_type'(req_opcode);
      stage_in.step   = STEP_W'(req_elapsed_ms) * STEP_W'(rate_per_ms);
      stage_in.value  = req_value;
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (!stage_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

### sv/tapc_core.sv
`timescale 1ns / 1ps
module tapc_core (
   input  logic                        clock,
   input  logic                        reset,
   input  tapc_pkg::cfg_type           cfg,
   input  logic                        stage_valid,
   output logic                        stage_stall,
   input  tapc_pkg::stage_type         stage,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_motion_state,
   output logic                        rsp_direction_up,
   output logic                        rsp_left_enable,
   output logic                        rsp_right_enable,
   output logic [tapc_pkg::PCT_W-1:0]  rsp_position_percent,
   output logic                        rsp_stopped_now
);
   import tapc_pkg::*;

   mode_type             mode_ff, mode_in;
   logic [VAL_W-1:0]     position_ff, position_in;
   logic [VAL_W-1:0]     target_ff, target_in;
   logic                 stop_c;

   logic                 res_valid_ff, res_valid_in;
   logic [1:0]           res_state_ff, res_state_in;
   logic                 res_up_ff, res_up_in;
   logic                 res_left_ff, res_left_in;
   logic                 res_right_ff, res_right_in;
   logic [PCT_W-1:0]     res_pct_ff, res_pct_in;
   logic                 res_stop_ff, res_stop_in;

   logic                 adv;
   logic [VAL_W:0]       pct_sum;
   logic signed [ARITH_W-1:0] pos_s, tgt_s, eps_s, step_s, full_s;

   function automatic logic [VAL_W-1:0] clamp_full(input logic signed [ARITH_W-1:0] v);
      logic [VAL_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > signed'(ARITH_W'(FULL_SCALE))) begin
         r = FULL_SCALE;
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

   assign adv         = stage_valid && (!res_valid_ff || !rsp_stall);
   assign stage_stall = !adv;

   assign pos_s  = signed'(ARITH_W'(position_ff));
   assign tgt_s  = signed'(ARITH_W'(target_ff));
   assign eps_s  = signed'(ARITH_W'(cfg.deadband));
   assign step_s = signed'(ARITH_W'(stage.step));
   assign full_s = signed'(ARITH_W'(FULL_SCALE));

   // next state
   always_comb begin
      mode_type                  run_mode;
      logic signed [ARITH_W-1:0] moved;
      logic [VAL_W-1:0]          clamped;
      mode_in     = mode_ff;
      position_in = position_ff;
      target_in   = target_ff;
      stop_c      = 1'b0;
      run_mode    = mode_ff;
      moved       = pos_s;
      clamped     = position_ff;
      unique case (stage.opcode)
         OP_TICK: begin
            if (mode_ff == MODE_STOPPED) begin
               if (tgt_s - eps_s > pos_s) begin
                  run_mode = MODE_OPENING;
               end else if (tgt_s + eps_s < pos_s) begin
                  run_mode = MODE_CLOSING;
               end
            end
            unique case (run_mode)
               MODE_OPENING: begin
                  moved  = pos_s + step_s;
                  stop_c = (moved >= tgt_s - eps_s) || (moved + eps_s >= full_s);
               end
               MODE_CLOSING: begin
                  moved  = pos_s - step_s;
                  stop_c = (moved <= tgt_s + eps_s) || (moved - eps_s <= 0);
               end
               default: ;
            endcase
            clamped     = clamp_full(moved);
            position_in = clamped;
            if (stop_c) begin
               mode_in   = MODE_STOPPED;
               target_in = clamped;
            end else begin
               mode_in = run_mode;
            end
         end
         OP_SET_TARGET: begin
            target_in = stage.value;
         end
         OP_RESTORE: begin
            clamped     = (stage.value > FULL_SCALE) ? FULL_SCALE : stage.value;
            position_in = clamped;
            target_in   = clamped;
         end
         OP_NONE: ;
         default: ;
      endcase
   end

   // result fields
   always_comb begin
      logic moving;
      moving       = (mode_in == MODE_OPENING) || (mode_in == MODE_CLOSING);
      pct_sum      = {1'b0, position_in} + (VAL_W+1)'(HALF_PERCENT);
      res_state_in = mode_in;
      res_up_in    = (mode_in == MODE_OPENING);
      res_left_in  = moving && cfg.use_left_motor;
      res_right_in = moving && cfg.use_right_motor;
      res_pct_in   = pct_sum[16 +: PCT_W];
      res_stop_in  = stop_c;
   end

   always_comb begin
      if (adv) begin
         res_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         res_valid_in = 1'b0;
      end else begin
         res_valid_in = res_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_STOPPED;
         position_ff  <= '0;
         target_ff    <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
         if (adv) begin
            mode_ff     <= mode_in;
            position_ff <= position_in;
            target_ff   <= target_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_state_ff <= res_state_in;
         res_up_ff    <= res_up_in;
         res_left_ff  <= res_left_in;
         res_right_ff <= res_right_in;
         res_pct_ff   <= res_pct_in;
         res_stop_ff  <= res_stop_in;
      end
   end

   assign rsp_valid            = res_valid_ff;
   assign rsp_motion_state     = res_state_ff;
   assign rsp_direction_up     = res_up_ff;
   assign rsp_left_enable      = res_left_ff;
   assign rsp_right_enable     = res_right_ff;
   assign rsp_position_percent = res_pct_ff;
   assign rsp_stopped_now      = res_stop_ff;

   a_stop_syncs_target: assert property (@(posedge clock) disable iff (reset)
      adv && stop_c |=> target_ff == position_ff && mode_ff == MODE_STOPPED)
      else $error("target not aligned with position after stop");

   a_position_in_range: assert property (@(posedge clock) disable iff (reset)
      position_ff <= FULL_SCALE)
      else $error("position beyond full scale");

   a_stop_reports_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stopped_now |-> rsp_motion_state == MODE_STOPPED
         && !rsp_left_enable && !rsp_right_enable)
      else $error("stop event while reporting motion");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !adv |=> $stable(rsp_position_percent) && $stable(rsp_motion_state))
      else $error("result changed without a new item");

endmodule
